>>> rtl/obst_pkg.sv
// ----------------------------------------------------------------------------
// obst_pkg
// shared constants, types and helper functions of the optimal bst cost table
// ----------------------------------------------------------------------------
package obst_pkg;

	localparam int MAX_KEYS  = 16;
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 24;
	localparam int IDX_W     = 7;
	localparam int PROB_W    = 16;

	localparam int COLS       = MAX_KEYS + 1;
	localparam int COST_ROWS  = MAX_KEYS + 2;
	localparam int COST_DEPTH = COST_ROWS * COLS;
	localparam int ROOT_DEPTH = COLS * COLS;
	localparam int COST_AW    = $clog2(COST_DEPTH);
	localparam int ROOT_AW    = $clog2(ROOT_DEPTH);
	localparam int KEY_W      = $clog2(MAX_KEYS + 1);
	localparam int PTR_W      = $clog2(MAX_KEYS + 2);

	localparam int IN_FIELDS_W  = 2 * IDX_W + 2 * PROB_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 * IDX_W + VAL_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_USER_W   = 2;

	// input probability scaling
	localparam int SHL = (FRAC_BITS >= PROB_W) ? FRAC_BITS - PROB_W : 0;
	localparam int SHR = (FRAC_BITS < PROB_W) ? PROB_W - FRAC_BITS : 0;

	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [COST_AW-1:0] cost_addr_t;

	localparam val_t VAL_MAX = '1;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_W_RD,
		ST_W_ADD,
		ST_R_LOOP,
		ST_DONE,
		ST_RD_ENTRY,
		ST_RESP
	} state_t;

	function automatic val_t to_internal(input logic [PROB_W-1:0] p);
		logic [PROB_W+VAL_W-1:0] v;
		v = ({{VAL_W{1'b0}}, p} << SHL) >> SHR;
		return (v > (PROB_W + VAL_W)'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
	endfunction

	// row-major table address, row * COLS + col
	function automatic cost_addr_t cost_addr(input ptr_t row, input ptr_t col);
		return COST_AW'(row) * COST_AW'(COLS) + COST_AW'(col);
	endfunction

endpackage

>>> rtl/obst_ram.sv
// ----------------------------------------------------------------------------
// obst_ram
// single write port, single registered read port table memory
// ----------------------------------------------------------------------------
module obst_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 306
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/obst_satadd.sv
// ----------------------------------------------------------------------------
// obst_satadd
// shared three-operand saturating adder for weights and candidate costs
// ----------------------------------------------------------------------------
module obst_satadd
	import obst_pkg::*;
(
	input  val_t a,
	input  val_t b,
	input  val_t c,
	output val_t sum,
	output logic ovf
);

	logic [VAL_W+1:0] full;

	assign full = {2'b00, a} + {2'b00, b} + {2'b00, c};
	assign ovf  = full > {2'b00, VAL_MAX};
	assign sum  = ovf ? VAL_MAX : full[VAL_W-1:0];

endmodule

>>> rtl/optimal_bst_cost_table.sv
// ----------------------------------------------------------------------------
// optimal_bst_cost_table
// optimal binary search tree dynamic program with cost, weight and root tables
// ----------------------------------------------------------------------------
// Load beats (tuser = 0) store p[i] and q[i] for one key index and produce no
// result; a load beat with tlast set fixes the key count n = index and runs
// the textbook dynamic program, then returns e[1][n] and root[1][n]. Query
// beats (tuser = 1) return e[i][j] and root[i][j] from registered table
// reads. The build is run by one sequencer around a single saturating
// three-input adder and a compare: per table cell one weight read, one weight
// add, then one candidate root per cycle (two cost reads in flight, one add
// and compare), and at the end the entry e[1][n] is read back as the result.
// The input side is not ready during a build or a read; costs saturate at the
// top of the Q8.16 range and set the saturated flag, which is cleared when a
// build starts.
// ----------------------------------------------------------------------------
module optimal_bst_cost_table
	import obst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // index, column, key_prob, dummy_prob
	input  logic [0:0]            s_tuser,  // kind
	input  logic                  s_tlast,  // last load
	// result beats
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // row, col, cost, best_root
	output logic [OUT_USER_W-1:0] m_tuser   // entry_ok, saturated
);

	// input field unpacking
	logic              s_accept;
	logic [IDX_W-1:0]  in_index;
	logic [IDX_W-1:0]  in_column;
	logic [PROB_W-1:0] in_key_prob;
	logic [PROB_W-1:0] in_dummy_prob;
	kind_t             in_kind;
	logic              in_idx_ok;

	assign s_accept      = s_tvalid && s_tready;
	assign in_index      = s_tdata[IDX_W-1:0];
	assign in_column     = s_tdata[2*IDX_W-1:IDX_W];
	assign in_key_prob   = s_tdata[2*IDX_W+PROB_W-1:2*IDX_W];
	assign in_dummy_prob = s_tdata[2*IDX_W+2*PROB_W-1:2*IDX_W+PROB_W];
	assign in_kind       = kind_t'(s_tuser[0]);
	assign in_idx_ok     = in_index <= IDX_W'(MAX_KEYS);

	// control state
	state_t           state_q, state_nx;
	logic [KEY_W-1:0] key_count_q;
	logic             tables_ready_q;
	logic             overflow_q;
	ptr_t             i_q, l_q, r_q;
	ptr_t             r_s1;
	logic             vld_s1;
	logic             ok_q, rok_q;
	logic             m_valid_q;

	// payload
	val_t             key_probs_q   [MAX_KEYS+1];
	val_t             dummy_probs_q [MAX_KEYS+1];
	val_t             w_q;
	val_t             best_q;
	ptr_t             broot_q;
	logic [IDX_W-1:0] req_row_q, req_col_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	// table memories; the cost table is kept twice for two reads per cycle
	logic       cost_we, wt_we, root_we;
	cost_addr_t cost_waddr, wt_waddr;
	val_t       cost_wdata, wt_wdata;
	cost_addr_t cost_a_raddr, cost_b_raddr, wt_raddr;
	logic [ROOT_AW-1:0] root_waddr, root_raddr;
	logic [IDX_W-1:0]   root_wdata, root_rdata;
	val_t       cost_a_rdata, cost_b_rdata, wt_rdata;

	// sequencer helpers
	ptr_t       j_cur;
	logic       issue;
	logic       cell_done;
	logic       last_cell;
	logic       next_in_row;
	logic       init_end;
	logic       first_r;
	logic       take;
	val_t       best_nx;
	ptr_t       broot_nx;
	val_t       add_a, add_b, add_c, add_sum;
	logic       add_ovf;
	logic       out_load;

	// entry lookup
	logic [IDX_W:0] e_row, e_col, e_kc;
	logic           e_ok, e_rok;
	cost_addr_t     e_addr;

	assign j_cur       = i_q + l_q - ptr_t'(1);
	assign issue       = (state_q == ST_R_LOOP) && (r_q <= j_cur);
	assign cell_done   = vld_s1 && (r_s1 == j_cur);
	assign last_cell   = l_q == PTR_W'(key_count_q);
	assign next_in_row = ({1'b0, i_q} + {1'b0, l_q}) <= (PTR_W + 1)'(key_count_q);
	assign init_end    = {1'b0, i_q} == (PTR_W + 1)'(key_count_q) + (PTR_W + 1)'(1);

	// shared adder: weight step or candidate cost
	always_comb begin
		if (state_q == ST_W_ADD) begin
			add_a = wt_rdata;
			add_b = key_probs_q[j_cur[KEY_W-1:0]];
			add_c = dummy_probs_q[j_cur[KEY_W-1:0]];
		end else begin
			add_a = cost_a_rdata;
			add_b = cost_b_rdata;
			add_c = w_q;
		end
	end

	obst_satadd u_satadd (
		.a   (add_a),
		.b   (add_b),
		.c   (add_c),
		.sum (add_sum),
		.ovf (add_ovf)
	);

	// strict less-than keeps the smallest root among equal costs
	assign first_r  = r_s1 == i_q;
	assign take     = first_r || (add_sum < best_q);
	assign best_nx  = take ? add_sum : best_q;
	assign broot_nx = take ? r_s1 : broot_q;

	// entry range check for queries and build results
	assign e_row = {1'b0, req_row_q};
	assign e_col = {1'b0, req_col_q};
	assign e_kc  = (IDX_W + 1)'(key_count_q);
	assign e_ok  = tables_ready_q && (e_row != '0) && (e_row <= e_kc + (IDX_W + 1)'(1)) &&
	               (e_col + (IDX_W + 1)'(1) >= e_row) && (e_col <= e_kc);
	assign e_rok = e_ok && (e_col >= e_row);
	assign e_addr = e_ok ? cost_addr(req_row_q[PTR_W-1:0], req_col_q[PTR_W-1:0]) : '0;

	// memory ports
	always_comb begin
		cost_we    = (state_q == ST_INIT) || cell_done;
		cost_waddr = (state_q == ST_INIT) ? cost_addr(i_q, i_q - ptr_t'(1)) :
		             cost_addr(i_q, j_cur);
		cost_wdata = (state_q == ST_INIT) ? dummy_probs_q[KEY_W'(i_q - ptr_t'(1))] : best_nx;
		wt_we      = (state_q == ST_INIT) || (state_q == ST_W_ADD);
		wt_waddr   = cost_waddr;
		wt_wdata   = (state_q == ST_INIT) ? cost_wdata : add_sum;
		root_we    = cell_done;
		root_waddr = ROOT_AW'(cost_addr(i_q, j_cur));
		root_wdata = IDX_W'(broot_nx);
		cost_a_raddr = (state_q == ST_R_LOOP) ? cost_addr(i_q, r_q - ptr_t'(1)) : e_addr;
		cost_b_raddr = cost_addr(r_q + ptr_t'(1), j_cur);
		wt_raddr     = cost_addr(i_q, j_cur - ptr_t'(1));
		root_raddr   = e_rok ? e_addr[ROOT_AW-1:0] : '0;
	end

	obst_ram #(.WIDTH(VAL_W), .DEPTH(COST_DEPTH)) u_cost_a (
		.clk (clk), .we (cost_we), .waddr (cost_waddr), .wdata (cost_wdata),
		.raddr (cost_a_raddr), .rdata (cost_a_rdata)
	);

	obst_ram #(.WIDTH(VAL_W), .DEPTH(COST_DEPTH)) u_cost_b (
		.clk (clk), .we (cost_we), .waddr (cost_waddr), .wdata (cost_wdata),
		.raddr (cost_b_raddr), .rdata (cost_b_rdata)
	);

	obst_ram #(.WIDTH(VAL_W), .DEPTH(COST_DEPTH)) u_weight (
		.clk (clk), .we (wt_we), .waddr (wt_waddr), .wdata (wt_wdata),
		.raddr (wt_raddr), .rdata (wt_rdata)
	);

	obst_ram #(.WIDTH(IDX_W), .DEPTH(ROOT_DEPTH)) u_root (
		.clk (clk), .we (root_we), .waddr (root_waddr), .wdata (root_wdata),
		.raddr (root_raddr), .rdata (root_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign out_load = (state_q == ST_RESP) && (!m_valid_q || m_tready);

	always_comb begin
		state_nx = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_accept) begin
					if (in_kind == KIND_QUERY) begin
						state_nx = ST_RD_ENTRY;
					end else if (s_tlast) begin
						state_nx = in_idx_ok ? ST_INIT : ST_RD_ENTRY;
					end
				end
			end
			ST_INIT: begin
				if (init_end) begin
					state_nx = (key_count_q == '0) ? ST_DONE : ST_W_RD;
				end
			end
			ST_W_RD:  state_nx = ST_W_ADD;
			ST_W_ADD: state_nx = ST_R_LOOP;
			ST_R_LOOP: begin
				if (cell_done) begin
					state_nx = last_cell ? ST_DONE : ST_W_RD;
				end
			end
			ST_DONE:     state_nx = ST_RD_ENTRY;
			ST_RD_ENTRY: state_nx = ST_RESP;
			ST_RESP: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q    <= '0;
			tables_ready_q <= 1'b0;
			overflow_q     <= 1'b0;
			i_q            <= '0;
			l_q            <= '0;
			r_q            <= '0;
			r_s1           <= '0;
			vld_s1         <= 1'b0;
			ok_q           <= 1'b0;
			rok_q          <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			vld_s1 <= issue;
			r_s1   <= r_q;
			if (s_accept && (in_kind == KIND_LOAD)) begin
				tables_ready_q <= 1'b0;
				if (s_tlast && in_idx_ok) begin
					key_count_q <= in_index[KEY_W-1:0];
					overflow_q  <= 1'b0;
					i_q         <= ptr_t'(1);
				end
			end
			if (state_q == ST_INIT) begin
				if (init_end) begin
					i_q <= ptr_t'(1);
					l_q <= ptr_t'(1);
				end else begin
					i_q <= i_q + ptr_t'(1);
				end
			end
			if (state_q == ST_W_ADD) begin
				r_q <= i_q;
				if (add_ovf) begin
					overflow_q <= 1'b1;
				end
			end
			if (issue) begin
				r_q <= r_q + ptr_t'(1);
			end
			if (vld_s1 && add_ovf) begin
				overflow_q <= 1'b1;
			end
			if (cell_done) begin
				if (next_in_row) begin
					i_q <= i_q + ptr_t'(1);
				end else begin
					i_q <= ptr_t'(1);
					l_q <= l_q + ptr_t'(1);
				end
			end
			if (state_q == ST_DONE) begin
				tables_ready_q <= 1'b1;
			end
			if (state_q == ST_RD_ENTRY) begin
				ok_q  <= e_ok;
				rok_q <= e_rok;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept && (in_kind == KIND_LOAD) && in_idx_ok) begin
			key_probs_q[in_index[KEY_W-1:0]]   <= to_internal(in_key_prob);
			dummy_probs_q[in_index[KEY_W-1:0]] <= to_internal(in_dummy_prob);
		end
		if (s_accept) begin
			if (in_kind == KIND_QUERY) begin
				req_row_q <= in_index;
				req_col_q <= in_column;
			end else begin
				req_row_q <= IDX_W'(1);
				req_col_q <= in_index;
			end
		end
		if (state_q == ST_DONE) begin
			req_row_q <= IDX_W'(1);
			req_col_q <= IDX_W'(key_count_q);
		end
		if (state_q == ST_W_ADD) begin
			w_q <= add_sum;
		end
		if (vld_s1) begin
			best_q  <= best_nx;
			broot_q <= broot_nx;
		end
		if (out_load) begin
			m_data_q <= OUT_DATA_W'({rok_q ? root_rdata : {IDX_W{1'b0}},
			                         ok_q ? cost_a_rdata : {VAL_W{1'b0}},
			                         req_col_q, req_row_q});
			m_user_q <= {overflow_q, ok_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef ASSERT_OFF
	// no candidate may be in flight while new beats are taken
	a_idle_no_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !vld_s1)
		else $error("candidate in flight while idle");

	// a candidate root always lies inside the current key range
	a_root_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (r_s1 >= i_q) && (r_s1 <= j_cur))
		else $error("candidate root outside key range");

	// every cell visited by the build lies inside the table
	a_cell_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W_RD) |-> (j_cur <= PTR_W'(key_count_q)) && (i_q != '0))
		else $error("build cell outside table");

	// the build ends with a result read of the full range
	a_done_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (state_q == ST_RD_ENTRY) && tables_ready_q)
		else $error("build did not hand over to result read");
`endif

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the optimal bst cost table: loads probability sets,
// lets the block build its tables, queries entries and compares every result
// beat with a predictor of the dynamic program, under random stalls on both
// sides and long receiver hold-offs
// ----------------------------------------------------------------------------
module testbench
	import obst_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any accepted beat before the run is declared hung
	localparam int STALL_LIMIT = 12000;
	// print at most this many mismatch lines, count all of them
	localparam int MAX_REPORTS = 40;

	// result beat layout, lowest bits first
	localparam int ROW_LSB  = 0;
	localparam int COL_LSB  = ROW_LSB + IDX_W;
	localparam int COST_LSB = COL_LSB + IDX_W;
	localparam int ROOT_LSB = COST_LSB + VAL_W;

	localparam int RANDOM_BEATS = 720;

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		val_t             cost;
		logic [IDX_W-1:0] root;
		logic             ok;
		logic             sat;
	} table_entry_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [0:0]            s_tuser  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// shared control between the stimulus and the two stream processes
	bit          no_idle    = 1'b0;  // both sides run without random gaps
	int unsigned hold_left  = 0;     // receiver hold-off, counted down per cycle
	int unsigned beats_sent = 0;
	int unsigned errors     = 0;
	int unsigned idle_count = 0;

	// results still owed by the block, oldest first
	table_entry_t pending_entries[$];

	// predictor state: stored probabilities and the three tables
	val_t             key_w    [0:MAX_KEYS];
	val_t             dummy_w  [0:MAX_KEYS];
	val_t             cost_m   [0:COST_ROWS-1][0:COLS-1];
	val_t             weight_m [0:COST_ROWS-1][0:COLS-1];
	logic [IDX_W-1:0] root_m   [0:COLS-1][0:COLS-1];
	int unsigned      n_keys   = 0;
	bit               tables_ok = 1'b0;
	bit               sat_seen  = 1'b0;

	optimal_bst_cost_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// q0.16 input to the internal fraction width
	function automatic val_t prob_to_fixed(input logic [PROB_W-1:0] p);
		longint unsigned v;
		v = 64'(p);
		if (FRAC_BITS >= PROB_W)
			v = v << (FRAC_BITS - PROB_W);
		else
			v = v >> (PROB_W - FRAC_BITS);
		return (v > 64'(VAL_MAX)) ? VAL_MAX : val_t'(v);
	endfunction

	// any weight or cost sum past the top clips and marks the build
	function automatic val_t clip_sum(input longint unsigned sum);
		if (sum > 64'(VAL_MAX)) begin
			sat_seen = 1'b1;
			return VAL_MAX;
		end
		return val_t'(sum);
	endfunction

	// textbook optimal bst program over keys 1..n
	function automatic void solve_tables(input int unsigned n);
		val_t        w;
		val_t        t;
		val_t        best;
		int unsigned j;
		int unsigned best_r;
		sat_seen = 1'b0;
		for (int unsigned i = 1; i <= n + 1; i++) begin
			cost_m[i][i-1]   = dummy_w[i-1];
			weight_m[i][i-1] = dummy_w[i-1];
		end
		for (int unsigned l = 1; l <= n; l++) begin
			for (int unsigned i = 1; i + l <= n + 1; i++) begin
				j = i + l - 1;
				w = clip_sum(64'(weight_m[i][j-1]) + 64'(key_w[j]) + 64'(dummy_w[j]));
				weight_m[i][j] = w;
				best   = '0;
				best_r = i;
				// strict less-than: the first best root is kept
				for (int unsigned r = i; r <= j; r++) begin
					t = clip_sum(64'(cost_m[i][r-1]) + 64'(cost_m[r+1][j]) + 64'(w));
					if (r == i || t < best) begin
						best   = t;
						best_r = r;
					end
				end
				cost_m[i][j] = best;
				root_m[i][j] = IDX_W'(best_r);
			end
		end
	endfunction

	// entry (i,j) as the block reports it
	function automatic table_entry_t table_lookup(input int unsigned i, input int unsigned j);
		table_entry_t e;
		bit           ok;
		ok = tables_ok && i >= 1 && i <= n_keys + 1 && j + 1 >= i && j <= n_keys;
		e.row  = IDX_W'(i);
		e.col  = IDX_W'(j);
		e.cost = '0;
		e.root = '0;
		if (ok) begin
			e.cost = cost_m[i][j];
			// empty range has no root
			if (j >= i)
				e.root = root_m[i][j];
		end
		e.ok  = ok;
		e.sat = sat_seen;
		return e;
	endfunction

	// update the predictor with one accepted input beat
	function automatic void predict_beat(input kind_t kind, input logic [IDX_W-1:0] index,
			input logic [IDX_W-1:0] column, input logic [PROB_W-1:0] kp,
			input logic [PROB_W-1:0] dp, input logic last);
		if (kind == KIND_QUERY) begin
			pending_entries.push_back(table_lookup(index, column));
			return;
		end
		// any load invalidates the tables until the next good build
		tables_ok = 1'b0;
		if (index <= MAX_KEYS) begin
			key_w[index]   = prob_to_fixed(kp);
			dummy_w[index] = prob_to_fixed(dp);
		end
		if (!last)
			return;
		if (index <= MAX_KEYS) begin
			n_keys = index;
			solve_tables(n_keys);
			tables_ok = 1'b1;
		end
		pending_entries.push_back(table_lookup(1, index));
	endfunction

	// ------------------------------------------------------------------------
	// stream side processes
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (errors < MAX_REPORTS)
			$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task automatic check_field(input string what, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 18);
		end
	end

	// compare each result beat with the oldest owed entry
	always @(posedge clk) begin : check_results
		table_entry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_entries.size() == 0) begin
				report_mismatch("result beat with nothing owed, row", m_tdata[ROW_LSB +: IDX_W], 0);
			end else begin
				want = pending_entries.pop_front();
				check_field("row", m_tdata[ROW_LSB +: IDX_W], want.row);
				check_field("col", m_tdata[COL_LSB +: IDX_W], want.col);
				check_field("cost", m_tdata[COST_LSB +: VAL_W], want.cost);
				check_field("best_root", m_tdata[ROOT_LSB +: IDX_W], want.root);
				check_field("entry_ok", m_tuser[0], want.ok);
				check_field("saturated", m_tuser[1], want.sat);
			end
		end
	end

	// watchdog: counts cycles in which neither side moves a beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_count <= 0;
		end else if (idle_count >= STALL_LIMIT) begin
			$display("timeout with %0d results owed", pending_entries.size());
			$display("FAILURE");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offer one beat and wait until it is taken; valid stays high afterwards
	// so back-to-back beats do not toggle it within one step
	task automatic send_beat(input kind_t kind, input logic [IDX_W-1:0] index,
			input logic [IDX_W-1:0] column, input logic [PROB_W-1:0] kp,
			input logic [PROB_W-1:0] dp, input logic last);
		if (!no_idle && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tlast  <= last;
		s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, dp, kp, column, index};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		predict_beat(kind, index, column, kp, dp, last);
	endtask

	// sender stops and waits for every owed result
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
	endtask

	function automatic logic [PROB_W-1:0] rand_prob();
		case ($urandom_range(3))
			0: return PROB_W'($urandom);
			1: return $urandom_range(1) ? '1 : '0;
			default: return PROB_W'($urandom_range(4095));
		endcase
	endfunction

	task automatic send_load(input int unsigned index, input logic last);
		send_beat(KIND_LOAD, IDX_W'(index), IDX_W'($urandom), rand_prob(), rand_prob(), last);
	endtask

	// query with random contents in the ignored fields
	task automatic send_query(input int unsigned i, input int unsigned j);
		send_beat(KIND_QUERY, IDX_W'(i), IDX_W'(j), PROB_W'($urandom), PROB_W'($urandom),
			1'($urandom));
	endtask

	// mostly a valid entry of the current tables, else near or far outside
	task automatic send_random_query();
		int unsigned i;
		int unsigned j;
		if (tables_ok && $urandom_range(99) < 80) begin
			i = $urandom_range(1, n_keys + 1);
			j = $urandom_range(i - 1, n_keys);
		end else if ($urandom_range(1)) begin
			i = $urandom_range(0, MAX_KEYS + 2);
			j = $urandom_range(0, MAX_KEYS + 1);
		end else begin
			i = $urandom_range(127);
			j = $urandom_range(127);
		end
		send_query(i, j);
	endtask

	// one well-formed load set: indices 0..n-1 in random order, then n as last
	task automatic send_frame(input int unsigned n);
		int unsigned order[$];
		int unsigned k;
		int unsigned tmp;
		for (int unsigned x = 0; x < n; x++)
			order.push_back(x);
		for (int x = int'(n) - 1; x > 0; x--) begin
			k = $urandom_range(x);
			tmp = order[x];
			order[x] = order[k];
			order[k] = tmp;
		end
		foreach (order[x]) begin
			send_load(order[x], 1'b0);
			// now and then a load past the table, which is dropped
			if ($urandom_range(99) < 4)
				send_load($urandom_range(MAX_KEYS + 1, 127), 1'b0);
		end
		send_load(n, 1'b1);
	endtask

	// mostly small key counts, a few up to the full size
	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(0, 5);
		if (r < 95)
			return $urandom_range(6, 11);
		return $urandom_range(12, MAX_KEYS);
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// nothing built yet: every entry is reported as missing
	task automatic test_query_before_build();
		send_query(1, 0);
		send_query(127, 127);
	endtask

	// every index written with the largest probabilities, the costliest tree
	task automatic test_full_load_max();
		for (int unsigned x = 0; x <= MAX_KEYS; x++)
			send_beat(KIND_LOAD, IDX_W'(x), IDX_W'($urandom), '1, '1, x == MAX_KEYS);
		send_query(MAX_KEYS + 1, MAX_KEYS);
		send_query(9, 4);
		send_query(5, 12);
	endtask

	// key count zero: result is the lone dummy cost with no root
	task automatic test_zero_keys();
		send_beat(KIND_LOAD, '0, IDX_W'($urandom), 16'h1234, 16'habcd, 1'b1);
	endtask

	// loads past the table are dropped; an oversized last load builds nothing
	task automatic test_oversized_loads();
		send_beat(KIND_LOAD, 7'd100, '0, 16'h5555, 16'haaaa, 1'b0);
		send_beat(KIND_LOAD, 7'd127, 7'd127, '1, '0, 1'b1);
		send_query(1, 0);
	endtask

	// all-zero probabilities: every root ties and the first one must win
	task automatic test_equal_costs();
		for (int unsigned x = 0; x < 3; x++)
			send_beat(KIND_LOAD, IDX_W'(x), '0, '0, '0, 1'b0);
		send_beat(KIND_LOAD, 7'd3, '0, '0, '0, 1'b1);
		send_query(2, 3);
	endtask

	// a plain load after a build hides the tables again
	task automatic test_load_clears();
		send_beat(KIND_LOAD, 7'd1, '0, 16'h0100, 16'h0200, 1'b0);
		send_query(1, 3);
		wait_all_results();
	endtask

	// receiver holds off while the sender keeps offering, so input stalls
	task automatic test_receiver_hold();
		send_frame(4);
		hold_left = 300;
		repeat (8) send_random_query();
		send_frame(7);
		hold_left = 250;
		repeat (6) send_random_query();
		wait_all_results();
	endtask

	// mixed traffic: load sets with queries, stray and broken loads, bare queries
	task automatic test_random_traffic(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		target = beats_sent + count;
		while (beats_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_frame(pick_size());
			end else if (pick < 58) begin
				if ($urandom_range(1))
					send_load($urandom_range(MAX_KEYS + 1, 127), 1'b1);
				else
					send_load($urandom_range(127), 1'b0);
			end
			repeat ($urandom_range(1, 4)) send_random_query();
			// occasionally let the block drain completely
			if ($urandom_range(99) < 5)
				wait_all_results();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_query_before_build();
		test_full_load_max();
		test_zero_keys();
		test_oversized_loads();
		test_equal_costs();
		test_load_clears();
		test_receiver_hold();

		// a stretch with no gaps on either side
		no_idle = 1'b1;
		test_random_traffic(120);
		no_idle = 1'b0;
		test_random_traffic(RANDOM_BEATS - 120);

		wait_all_results();
		// room for any stray result beat
		repeat (40) @(posedge clk);
		if (pending_entries.size() != 0)
			report_mismatch("results never returned", 0, pending_entries.size());

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
